// File: rtl/npi_pkg.sv
// Shared types, constants and palette level tables for the nearest palette index core.
// No dependencies; every other file of the block refers to it by scoped names.
package npi_pkg;

  localparam int CH_W        = 8;   // one color channel
  localparam int DIST_W      = 10;  // sum of three channel distances
  localparam int IDX_W       = 8;   // palette index
  localparam int LVL_W       = 3;   // level number along one cube axis
  localparam int NR          = 6;   // red levels
  localparam int NG          = 8;   // green levels
  localparam int NB          = 6;   // blue levels (last one only partly populated)
  localparam int COLORS_W    = 9;
  localparam int BITS_W      = 4;
  localparam int MAX_COLORS  = 256;
  localparam int BLOCK_SIZE  = NR * NG;  // entries sharing one blue level
  localparam int ROW_SIZE    = NR;       // entries sharing one green and blue level
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_COLORS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_BITS   = 1'b1;

  // Search setup derived from the registers at write time.
  // blocks: whole blue planes searched; rows: whole green rows in the next plane;
  // cols: red entries in the next row.
  typedef struct packed {
    logic [CH_W-1:0]  mask;
    logic [LVL_W-1:0] blocks;
    logic [LVL_W-1:0] rows;
    logic [LVL_W-1:0] cols;
  } search_cfg_t;

  // Per-axis channel distances.
  typedef struct packed {
    logic [NR-1:0][CH_W-1:0] dr;
    logic [NG-1:0][CH_W-1:0] dg;
    logic [NB-1:0][CH_W-1:0] db;
  } diff_t;

  // Per-axis minima feeding the three candidate sums.
  typedef struct packed {
    logic [CH_W-1:0]  r_min;
    logic [LVL_W-1:0] r_idx;
    logic [CH_W-1:0]  g_min;
    logic [LVL_W-1:0] g_idx;
    logic             bp_ok;
    logic [CH_W-1:0]  bp_min;
    logic [LVL_W-1:0] bp_idx;
    logic             gp_ok;
    logic [CH_W-1:0]  gp_min;
    logic [LVL_W-1:0] gp_idx;
    logic             rp_ok;
    logic [CH_W-1:0]  rp_min;
    logic [LVL_W-1:0] rp_idx;
    logic [CH_W-1:0]  db_part;
    logic [CH_W-1:0]  dg_part;
  } reduce_t;

  // Candidates in ascending index order: whole planes, whole rows, partial row.
  typedef struct packed {
    logic              a_ok;
    logic [DIST_W-1:0] a_dist;
    logic [IDX_W-1:0]  a_idx;
    logic              b_ok;
    logic [DIST_W-1:0] b_dist;
    logic [IDX_W-1:0]  b_idx;
    logic              c_ok;
    logic [DIST_W-1:0] c_dist;
    logic [IDX_W-1:0]  c_idx;
  } cand_t;

  function automatic logic [CH_W-1:0] red_level(input logic [LVL_W-1:0] k);
    logic [CH_W-1:0] v;
    unique case (k)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd51;
      3'd2:    v = 8'd102;
      3'd3:    v = 8'd153;
      3'd4:    v = 8'd204;
      3'd5:    v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [CH_W-1:0] green_level(input logic [LVL_W-1:0] k);
    logic [CH_W-1:0] v;
    unique case (k)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd72;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd145;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd218;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // Top level wraps past 255 to 62.
  function automatic logic [CH_W-1:0] blue_level(input logic [LVL_W-1:0] k);
    logic [CH_W-1:0] v;
    unique case (k)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd63;
      3'd2:    v = 8'd127;
      3'd3:    v = 8'd191;
      3'd4:    v = 8'd255;
      3'd5:    v = 8'd62;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/nearest_palette_index_core.sv
// Nearest palette index: maps an RGB pixel to the closest entry of a built-in 6x8x6 color
// cube by sum of absolute channel differences, lowest index on ties. Takes one pixel per
// cycle while the result side does not stall; each result passes through four register
// stages (axis distances, axis minima, candidate sums, pick). A stall on the result side
// holds the whole pipeline and is passed back to the pixel side in the same cycle.
// Configuration writes are always accepted. Depends on npi_pkg and the npi_* stage modules.
module nearest_palette_index_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [npi_pkg::CH_W-1:0]         red,
  input  logic [npi_pkg::CH_W-1:0]         green,
  input  logic [npi_pkg::CH_W-1:0]         blue,
  output logic                             index_valid,
  input  logic                             index_stall,
  output logic [npi_pkg::IDX_W-1:0]        palette_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [npi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [npi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  npi_pkg::search_cfg_t search_cfg;
  npi_pkg::diff_t       diff;
  npi_pkg::reduce_t     red_min;
  logic                 advance;
  logic                 diff_valid;
  logic                 reduce_valid;

  // Advance when the result register is empty or its transfer happens now.
  assign advance     = !index_valid || !index_stall;
  assign pixel_stall = !advance;
  assign cfg_ready   = 1'b1;

  npi_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .search_cfg (search_cfg)
  );

  npi_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .valid_in  (pixel_valid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .mask      (search_cfg.mask),
    .valid_out (diff_valid),
    .diff_out  (diff)
  );

  npi_reduce u_reduce (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .valid_in   (diff_valid),
    .diff_in    (diff),
    .search_cfg (search_cfg),
    .valid_out  (reduce_valid),
    .red_out    (red_min)
  );

  npi_select u_select (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .valid_in   (reduce_valid),
    .red_in     (red_min),
    .search_cfg (search_cfg),
    .valid_out  (index_valid),
    .index_out  (palette_index)
  );

endmodule

// File: rtl/npi_cfg.sv
// Configuration registers: entry count split into planes, rows and columns, and channel mask.
// Depends on npi_pkg.
module npi_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [npi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [npi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output npi_pkg::search_cfg_t             search_cfg
);

  npi_pkg::search_cfg_t search;

  logic [npi_pkg::COLORS_W-1:0] count;
  logic [npi_pkg::LVL_W-1:0]    blocks_next;
  logic [npi_pkg::COLORS_W-1:0] rem_full;
  logic [5:0]                   rem;
  logic [npi_pkg::LVL_W-1:0]    rows_next;
  logic [5:0]                   col_full;
  logic [npi_pkg::LVL_W-1:0]    cols_next;
  logic [npi_pkg::BITS_W-1:0]   bits;
  logic [15:0]                  mask_wide;
  logic [npi_pkg::CH_W-1:0]     mask_next;

  always_comb begin
    count = cfg_data[npi_pkg::COLORS_W-1:0];
    if (count > npi_pkg::COLORS_W'(npi_pkg::MAX_COLORS)) begin
      count = npi_pkg::COLORS_W'(npi_pkg::MAX_COLORS);
    end

    priority if (count >= 9'd240) blocks_next = 3'd5;
    else if (count >= 9'd192)     blocks_next = 3'd4;
    else if (count >= 9'd144)     blocks_next = 3'd3;
    else if (count >= 9'd96)      blocks_next = 3'd2;
    else if (count >= 9'd48)      blocks_next = 3'd1;
    else                          blocks_next = 3'd0;

    rem_full = count - {6'd0, blocks_next} * 9'(npi_pkg::BLOCK_SIZE);
    rem      = rem_full[5:0];

    priority if (rem >= 6'd42) rows_next = 3'd7;
    else if (rem >= 6'd36)     rows_next = 3'd6;
    else if (rem >= 6'd30)     rows_next = 3'd5;
    else if (rem >= 6'd24)     rows_next = 3'd4;
    else if (rem >= 6'd18)     rows_next = 3'd3;
    else if (rem >= 6'd12)     rows_next = 3'd2;
    else if (rem >= 6'd6)      rows_next = 3'd1;
    else                       rows_next = 3'd0;

    col_full  = rem - {3'd0, rows_next} * 6'(npi_pkg::ROW_SIZE);
    cols_next = col_full[npi_pkg::LVL_W-1:0];

    bits = cfg_data[npi_pkg::BITS_W-1:0];
    if (bits > 4'd8) begin
      bits = 4'd8;
    end
    mask_wide = 16'hFF00 >> bits;
    mask_next = mask_wide[npi_pkg::CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search.mask   <= 8'hFF;
      search.blocks <= 3'd5;
      search.rows   <= 3'd2;
      search.cols   <= 3'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        npi_pkg::REG_PALETTE_COLORS: begin
          search.blocks <= blocks_next;
          search.rows   <= rows_next;
          search.cols   <= cols_next;
        end
        npi_pkg::REG_PALETTE_BITS: begin
          search.mask <= mask_next;
        end
        default: begin
          search <= search;
        end
      endcase
    end
  end

  assign search_cfg = search;

endmodule

// File: rtl/npi_dist.sv
// Pipeline stage 1: distance from the pixel to every masked level of each cube axis.
// Depends on npi_pkg.
module npi_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          valid_in,
  input  logic [npi_pkg::CH_W-1:0]      red,
  input  logic [npi_pkg::CH_W-1:0]      green,
  input  logic [npi_pkg::CH_W-1:0]      blue,
  input  logic [npi_pkg::CH_W-1:0]      mask,
  output logic                          valid_out,
  output npi_pkg::diff_t                diff_out
);

  npi_pkg::diff_t diff_next;
  npi_pkg::diff_t diff;
  logic           valid;

  function automatic logic [npi_pkg::CH_W-1:0] absdiff(input logic [npi_pkg::CH_W-1:0] a,
                                                       input logic [npi_pkg::CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    for (int k = 0; k < npi_pkg::NR; k++) begin
      diff_next.dr[k] = absdiff(red, npi_pkg::red_level(3'(k)) & mask);
    end
    for (int k = 0; k < npi_pkg::NG; k++) begin
      diff_next.dg[k] = absdiff(green, npi_pkg::green_level(3'(k)) & mask);
    end
    for (int k = 0; k < npi_pkg::NB; k++) begin
      diff_next.db[k] = absdiff(blue, npi_pkg::blue_level(3'(k)) & mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      diff <= diff_next;
    end
  end

  assign valid_out = valid;
  assign diff_out  = diff;

endmodule

// File: rtl/npi_reduce.sv
// Pipeline stage 2: per-axis minima, full and over the searched prefix, lowest level on ties.
// Depends on npi_pkg.
module npi_reduce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 valid_in,
  input  npi_pkg::diff_t       diff_in,
  input  npi_pkg::search_cfg_t search_cfg,
  output logic                 valid_out,
  output npi_pkg::reduce_t     red_out
);

  npi_pkg::reduce_t red_next;
  npi_pkg::reduce_t red;
  logic             valid;

  always_comb begin
    red_next = '0;

    // full minima of red and green
    red_next.r_min = diff_in.dr[0];
    for (int k = 1; k < npi_pkg::NR; k++) begin
      if (diff_in.dr[k] < red_next.r_min) begin
        red_next.r_min = diff_in.dr[k];
        red_next.r_idx = 3'(k);
      end
    end
    red_next.g_min = diff_in.dg[0];
    for (int k = 1; k < npi_pkg::NG; k++) begin
      if (diff_in.dg[k] < red_next.g_min) begin
        red_next.g_min = diff_in.dg[k];
        red_next.g_idx = 3'(k);
      end
    end

    // prefix minima bounded by the entry count
    for (int k = 0; k < npi_pkg::NB; k++) begin
      if (3'(k) < search_cfg.blocks && (!red_next.bp_ok || diff_in.db[k] < red_next.bp_min)) begin
        red_next.bp_ok  = 1'b1;
        red_next.bp_min = diff_in.db[k];
        red_next.bp_idx = 3'(k);
      end
    end
    for (int k = 0; k < npi_pkg::NG; k++) begin
      if (3'(k) < search_cfg.rows && (!red_next.gp_ok || diff_in.dg[k] < red_next.gp_min)) begin
        red_next.gp_ok  = 1'b1;
        red_next.gp_min = diff_in.dg[k];
        red_next.gp_idx = 3'(k);
      end
    end
    for (int k = 0; k < npi_pkg::NR; k++) begin
      if (3'(k) < search_cfg.cols && (!red_next.rp_ok || diff_in.dr[k] < red_next.rp_min)) begin
        red_next.rp_ok  = 1'b1;
        red_next.rp_min = diff_in.dr[k];
        red_next.rp_idx = 3'(k);
      end
    end

    red_next.db_part = diff_in.db[search_cfg.blocks];
    red_next.dg_part = diff_in.dg[search_cfg.rows];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red <= red_next;
    end
  end

  assign valid_out = valid;
  assign red_out   = red;

endmodule

// File: rtl/npi_select.sv
// Pipeline stages 3 and 4: candidate distances and indexes, then the strict-less pick.
// Depends on npi_pkg.
module npi_select (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      valid_in,
  input  npi_pkg::reduce_t          red_in,
  input  npi_pkg::search_cfg_t      search_cfg,
  output logic                      valid_out,
  output logic [npi_pkg::IDX_W-1:0] index_out
);

  npi_pkg::cand_t            cand_next;
  npi_pkg::cand_t            cand;
  logic                      cand_valid;
  logic                      have;
  logic [npi_pkg::DIST_W-1:0] best;
  logic [npi_pkg::IDX_W-1:0] pick;
  logic                      out_valid;
  logic [npi_pkg::IDX_W-1:0] out_index;

  function automatic logic [npi_pkg::IDX_W-1:0] entry(input logic [npi_pkg::LVL_W-1:0] b,
                                                      input logic [npi_pkg::LVL_W-1:0] g,
                                                      input logic [npi_pkg::LVL_W-1:0] r);
    logic [8:0] sum;
    sum = {6'd0, b} * 9'(npi_pkg::BLOCK_SIZE) + {6'd0, g} * 9'(npi_pkg::ROW_SIZE) + {6'd0, r};
    return sum[npi_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [npi_pkg::DIST_W-1:0] add3(input logic [npi_pkg::CH_W-1:0] a,
                                                      input logic [npi_pkg::CH_W-1:0] b,
                                                      input logic [npi_pkg::CH_W-1:0] c);
    return {2'd0, a} + {2'd0, b} + {2'd0, c};
  endfunction

  always_comb begin
    cand_next.a_ok   = red_in.bp_ok;
    cand_next.a_dist = add3(red_in.bp_min, red_in.g_min, red_in.r_min);
    cand_next.a_idx  = entry(red_in.bp_idx, red_in.g_idx, red_in.r_idx);
    cand_next.b_ok   = red_in.gp_ok;
    cand_next.b_dist = add3(red_in.db_part, red_in.gp_min, red_in.r_min);
    cand_next.b_idx  = entry(search_cfg.blocks, red_in.gp_idx, red_in.r_idx);
    cand_next.c_ok   = red_in.rp_ok;
    cand_next.c_dist = add3(red_in.db_part, red_in.dg_part, red_in.rp_min);
    cand_next.c_idx  = entry(search_cfg.blocks, search_cfg.rows, red_in.rp_idx);
  end

  // Candidates arrive in ascending index order, so strict less keeps the lowest on ties.
  always_comb begin
    have = cand.a_ok;
    best = cand.a_dist;
    pick = cand.a_ok ? cand.a_idx : '0;
    if (cand.b_ok && (!have || cand.b_dist < best)) begin
      have = 1'b1;
      best = cand.b_dist;
      pick = cand.b_idx;
    end
    if (cand.c_ok && (!have || cand.c_dist < best)) begin
      pick = cand.c_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      cand_valid <= valid_in;
      out_valid  <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cand      <= cand_next;
      out_index <= pick;
    end
  end

  assign valid_out = out_valid;
  assign index_out = out_index;

endmodule
